// ----- design/assert_macros.svh -----
// Assertion helpers used by the supervisor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define LSIS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that a condition never holds, disabled while reset is asserted.
`define LSIS_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- design/lsis_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Lift safety interlock supervisor package
// Command and mode codes, item layouts and reset values.
// ----------------------------------------------------------------------------
package lsis_pkg;

  localparam int CMD_W  = 2;
  localparam int MODE_W = 2;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  localparam logic [CMD_W-1:0] CMD_POLL  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOCK  = 2'd2;

  localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ESTOP  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PHOTO  = 2'd2;

  localparam logic LOWER_MASKS_PHOTO_RST = 1'b1;

  typedef struct packed {
    logic motion_active;
    logic buttons_idle;
    logic lower_limit_in;
    logic photo_in;
    logic estop_in;
    logic lock_value;
  } in_item_t;

  typedef struct packed {
    logic              alarm_cleared;
    logic              photo_tripped;
    logic              estop_released;
    logic              estop_tripped;
    logic              force_idle;
    logic              run_product;
    logic              emergency_off;
    logic              all_off;
    logic [MODE_W-1:0] mode;
  } out_item_t;

endpackage
`default_nettype wire

// ----- design/lift_safety_interlock_supervisor_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Lift safety interlock supervisor
// Priority safety supervisor: mode, remote lock, remote-clear and re-arm flags.
// ----------------------------------------------------------------------------
// An item can be taken in every clock cycle and gives exactly one result item.
// Each item is held in the input register until the result register is free
// or its result is being taken; it then runs through the priority logic into
// the result register, where the supervisor state is updated as well, and is
// offered there. The result register is refilled in the cycle it is taken, so
// throughput is one item per cycle while out_tready stays high; while a result
// waits, the input register holds one more item and in_tready then drops
// until the result is taken. The configuration register is always ready and
// should only be written while the block is empty.
module lift_safety_interlock_supervisor_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_valid,
  output      logic                            cfg_ready,
  input  wire logic                            cfg_data,    // lower_limit_masks_photo
  input  wire logic                            in_tvalid,
  output      logic                            in_tready,
  // lock_value, estop_in, photo_in, lower_limit_in, buttons_idle, motion_active
  input  wire logic [lsis_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire logic [lsis_pkg::CMD_W-1:0]      in_tuser,    // cmd
  output      logic                            out_tvalid,
  input  wire logic                            out_tready,
  // mode[1:0], all_off, emergency_off, run_product, force_idle,
  // estop_tripped, estop_released, photo_tripped, alarm_cleared
  output      logic [lsis_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int InItemW  = $bits(lsis_pkg::in_item_t);
  localparam int OutItemW = $bits(lsis_pkg::out_item_t);

  logic                        lower_masks_r;
  logic                        s1_valid_r;
  logic [lsis_pkg::CMD_W-1:0]  s1_cmd_r;
  lsis_pkg::in_item_t          s1_item_r;
  logic                        out_valid_r;
  lsis_pkg::out_item_t         out_item_r;

  logic [lsis_pkg::MODE_W-1:0] mode_r, mode_nxt;
  logic                        lock_r, lock_nxt;
  logic                        nrc_r, nrc_nxt;
  logic                        rearm_r, rearm_nxt;
  lsis_pkg::out_item_t         res_nxt;

  logic advance;
  logic skip;
  logic just_rel;

  assign cfg_ready  = 1'b1;
  assign advance    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(lsis_pkg::OUT_DATA_W - OutItemW){1'b0}}, out_item_r};

  always_comb begin
    mode_nxt  = mode_r;
    lock_nxt  = lock_r;
    nrc_nxt   = nrc_r;
    rearm_nxt = rearm_r;
    res_nxt   = '0;
    skip      = lower_masks_r && s1_item_r.lower_limit_in;
    just_rel  = 1'b0;
    case (s1_cmd_r)
      lsis_pkg::CMD_POLL: begin
        if (s1_item_r.estop_in) begin
          if (mode_r != lsis_pkg::MODE_ESTOP) begin
            mode_nxt              = lsis_pkg::MODE_ESTOP;
            res_nxt.all_off       = 1'b1;
            res_nxt.estop_tripped = 1'b1;
            res_nxt.force_idle    = 1'b1;
          end
          rearm_nxt = 1'b1;
        end else begin
          if (mode_r == lsis_pkg::MODE_ESTOP) begin
            mode_nxt               = lsis_pkg::MODE_NORMAL;
            res_nxt.estop_released = 1'b1;
            res_nxt.force_idle     = 1'b1;
            just_rel               = 1'b1;
          end
          if (skip && mode_nxt == lsis_pkg::MODE_PHOTO && !nrc_r) begin
            mode_nxt              = lsis_pkg::MODE_NORMAL;
            res_nxt.alarm_cleared = 1'b1;
            res_nxt.force_idle    = 1'b1;
          end
          if (s1_item_r.photo_in && !skip) begin
            if (mode_nxt != lsis_pkg::MODE_PHOTO) begin
              nrc_nxt               = s1_item_r.motion_active && !just_rel;
              mode_nxt              = lsis_pkg::MODE_PHOTO;
              rearm_nxt             = 1'b1;
              res_nxt.all_off       = 1'b1;
              res_nxt.photo_tripped = 1'b1;
              res_nxt.force_idle    = 1'b1;
            end
          end else if (mode_nxt == lsis_pkg::MODE_PHOTO) begin
            if (!s1_item_r.photo_in && !nrc_r && s1_item_r.buttons_idle) begin
              mode_nxt              = lsis_pkg::MODE_NORMAL;
              res_nxt.alarm_cleared = 1'b1;
              res_nxt.force_idle    = 1'b1;
            end
          end else if (lock_r) begin
            res_nxt.emergency_off = 1'b1;
          end else begin
            if (rearm_r && s1_item_r.buttons_idle) begin
              rearm_nxt = 1'b0;
            end
            if (rearm_nxt) begin
              res_nxt.emergency_off = 1'b1;
            end else begin
              res_nxt.run_product = 1'b1;
            end
          end
        end
      end
      lsis_pkg::CMD_CLEAR: begin
        if (mode_r == lsis_pkg::MODE_PHOTO) begin
          mode_nxt              = lsis_pkg::MODE_NORMAL;
          nrc_nxt               = 1'b0;
          rearm_nxt             = 1'b1;
          res_nxt.alarm_cleared = 1'b1;
          res_nxt.force_idle    = 1'b1;
        end
      end
      lsis_pkg::CMD_LOCK: begin
        lock_nxt = s1_item_r.lock_value;
        if (s1_item_r.lock_value) begin
          if (mode_r == lsis_pkg::MODE_NORMAL) begin
            res_nxt.force_idle = 1'b1;
          end
          rearm_nxt       = 1'b1;
          res_nxt.all_off = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res_nxt.mode = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_masks_r <= lsis_pkg::LOWER_MASKS_PHOTO_RST;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      mode_r        <= lsis_pkg::MODE_NORMAL;
      lock_r        <= 1'b0;
      nrc_r         <= 1'b0;
      rearm_r       <= 1'b1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        lower_masks_r <= cfg_data;
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        mode_r      <= mode_nxt;
        lock_r      <= lock_nxt;
        nrc_r       <= nrc_nxt;
        rearm_r     <= rearm_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_cmd_r  <= in_tuser;
      s1_item_r <= in_tdata[InItemW-1:0];
    end
    if (advance) begin
      out_item_r <= res_nxt;
    end
  end

`include "assert_macros.svh"

  `LSIS_ASSERT(a_run_only_normal,
    out_valid_r && out_item_r.run_product |->
      out_item_r.mode == lsis_pkg::MODE_NORMAL && !out_item_r.emergency_off
      && !out_item_r.all_off,
    "run_product given outside normal mode or with outputs cut")
  `LSIS_ASSERT(a_trip_mode,
    out_valid_r && out_item_r.estop_tripped |-> out_item_r.mode == lsis_pkg::MODE_ESTOP,
    "estop_tripped without e-stop mode")
  `LSIS_ASSERT(a_estop_enters,
    advance && s1_cmd_r == lsis_pkg::CMD_POLL && s1_item_r.estop_in |=>
      mode_r == lsis_pkg::MODE_ESTOP && rearm_r,
    "e-stop poll did not leave e-stop mode with re-arm set")
  `LSIS_ASSERT_NEVER(a_trip_and_release,
    out_valid_r && out_item_r.estop_tripped && out_item_r.estop_released,
    "e-stop tripped and released in one item")

endmodule
`default_nettype wire
